// ----- src/nass_pkg.sv -----
// Shared types and constants of the bracket-aware separator splitter.
`default_nettype none

package nass_pkg;

    localparam int unsigned          NASS_MAX_NEST_DEF     = 255;
    localparam longint unsigned      NASS_MAX_ELEMENTS_DEF = 65535;
    localparam int unsigned          NASS_QUEUE_DEPTH_DEF  = 2;
    localparam logic [7:0]           NASS_SEP_RESET        = 8'd44;

    localparam logic [7:0] CH_SQ_OPEN    = 8'h5B;
    localparam logic [7:0] CH_SQ_CLOSE   = 8'h5D;
    localparam logic [7:0] CH_PAREN_OPEN = 8'h28;
    localparam logic [7:0] CH_PAREN_CLOSE = 8'h29;
    localparam logic [7:0] CH_CURLY_OPEN = 8'h7B;
    localparam logic [7:0] CH_CURLY_CLOSE = 8'h7D;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_SQUARE = 3'd1,
        KIND_PAREN  = 3'd2,
        KIND_CURLY  = 3'd3,
        KIND_QUOTE  = 3'd4
    } kind_t;

    localparam logic       ROLE_CONTENT = 1'b0;
    localparam logic       ROLE_SEP     = 1'b1;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNCLOSED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
        kind_t      open_kind;
        kind_t      close_kind;
        logic       is_sep;
        logic       is_bs;
    } item_t;

    typedef struct packed {
        logic [7:0]  char_out;
        logic        role;
        logic [15:0] element_number;
        logic        end_of_text;
        logic [1:0]  error_code;
    } res_t;

    typedef struct packed {
        logic        pop;
        logic        last;
        kind_t       kind;
        logic [15:0] count;
    } back_stat_t;

endpackage

`default_nettype wire

// ----- src/nested_aware_separator_splitter.sv -----
// Top level of the bracket-aware separator splitter.
//
// Input queue port: drive char_in and last_char with push; a byte is taken
// on a clock edge with push high and full low. Result queue port: while
// empty is low the oldest result word sits on char_out, role,
// element_number, end_of_text and error_code; pop high on an edge takes it.
// Configuration: separator_char is written on an edge with cfg_valid and
// cfg_ready high; cfg_ready is always high. Write only while no text is in
// flight. Reset value of the separator is ','.
// Throughput: one byte per cycle while full is low; the execution stage
// updates its state on each byte it takes. A taken byte passes the input
// register, middle queue and result queue before it shows on the result
// port. When pop stays low, the result queue, middle queue and input
// register fill in turn, then full rises; nothing is lost.
// Reset: all queues empty, group state at top level, element count zero.
// After the final byte of a text the group state returns to that state.
`default_nettype none

module nested_aware_separator_splitter #(
    parameter int unsigned     MAX_NEST     = nass_pkg::NASS_MAX_NEST_DEF,
    parameter longint unsigned MAX_ELEMENTS = nass_pkg::NASS_MAX_ELEMENTS_DEF,
    parameter int unsigned     QUEUE_DEPTH  = nass_pkg::NASS_QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  char_in,
    input  wire logic        last_char,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       char_out,
    output logic             role,
    output logic [15:0]      element_number,
    output logic             end_of_text,
    output logic [1:0]       error_code,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  separator_char
);

    logic                 [7:0] sep_reg;
    logic                 mid_wr;
    nass_pkg::item_t      mid_wr_data;
    logic                 mid_full;
    logic                 mid_rd;
    nass_pkg::item_t      mid_rd_data;
    logic                 mid_empty;
    logic                 out_wr;
    nass_pkg::res_t       out_wr_data;
    logic                 out_full;
    nass_pkg::res_t       out_rd_data;
    logic                 front_valid;
    nass_pkg::back_stat_t back_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg <= nass_pkg::NASS_SEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sep_reg <= separator_char;
        end
    end

    nass_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .char_in     (char_in),
        .last_char   (last_char),
        .sep         (sep_reg),
        .q_wr        (mid_wr),
        .q_data      (mid_wr_data),
        .q_full      (mid_full),
        .front_valid (front_valid)
    );

    nass_fifo #(
        .WIDTH ($bits(nass_pkg::item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_wr),
        .wr_data (mid_wr_data),
        .full    (mid_full),
        .rd_en   (mid_rd),
        .rd_data (mid_rd_data),
        .empty   (mid_empty)
    );

    nass_back #(
        .MAX_NEST     (MAX_NEST),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (mid_empty),
        .q_data   (mid_rd_data),
        .q_rd     (mid_rd),
        .out_full (out_full),
        .out_wr   (out_wr),
        .out_data (out_wr_data),
        .stat     (back_stat)
    );

    nass_fifo #(
        .WIDTH ($bits(nass_pkg::res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr),
        .wr_data (out_wr_data),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_rd_data),
        .empty   (empty)
    );

    assign char_out       = out_rd_data.char_out;
    assign role           = out_rd_data.role;
    assign element_number = out_rd_data.element_number;
    assign end_of_text    = out_rd_data.end_of_text;
    assign error_code     = out_rd_data.error_code;

    a_push_loads_front: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> front_valid)
        else $error("accepted word did not load the input register");

    a_full_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> front_valid && mid_full)
        else $error("full raised without a backlog");

    a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.pop && back_stat.last |=>
            back_stat.kind == nass_pkg::KIND_NONE && back_stat.count == 16'd0)
        else $error("group state not cleared after final byte");

    a_unclosed_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && error_code == nass_pkg::ERR_UNCLOSED |-> end_of_text)
        else $error("unclosed group error on a byte that is not final");

endmodule

`default_nettype wire

// ----- src/nass_fifo.sv -----
// Small register queue used between the stages and at the result side.
`default_nettype none

module nass_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = nass_pkg::NASS_QUEUE_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/nass_front.sv -----
// Input stage: accept a byte and decode its bracket, quote and separator class.
`default_nettype none

module nass_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  char_in,
    input  wire logic        last_char,
    input  wire logic [7:0]  sep,
    output logic             q_wr,
    output nass_pkg::item_t  q_data,
    input  wire logic        q_full,
    output logic             front_valid
);

    logic            valid_reg;
    nass_pkg::item_t item_reg;
    nass_pkg::item_t item_next;
    logic            accept;

    assign full        = valid_reg && q_full;
    assign accept      = push && !full;
    assign q_wr        = valid_reg && !q_full;
    assign q_data      = item_reg;
    assign front_valid = valid_reg;

    always_comb
    begin
        item_next.char_in   = char_in;
        item_next.last_char = last_char;
        item_next.is_sep    = (char_in == sep);
        item_next.is_bs     = (char_in == nass_pkg::CH_BACKSLASH);
        unique case (char_in)
            nass_pkg::CH_SQ_OPEN:    item_next.open_kind = nass_pkg::KIND_SQUARE;
            nass_pkg::CH_PAREN_OPEN: item_next.open_kind = nass_pkg::KIND_PAREN;
            nass_pkg::CH_CURLY_OPEN: item_next.open_kind = nass_pkg::KIND_CURLY;
            nass_pkg::CH_QUOTE:      item_next.open_kind = nass_pkg::KIND_QUOTE;
            default:                 item_next.open_kind = nass_pkg::KIND_NONE;
        endcase
        unique case (char_in)
            nass_pkg::CH_SQ_CLOSE:    item_next.close_kind = nass_pkg::KIND_SQUARE;
            nass_pkg::CH_PAREN_CLOSE: item_next.close_kind = nass_pkg::KIND_PAREN;
            nass_pkg::CH_CURLY_CLOSE: item_next.close_kind = nass_pkg::KIND_CURLY;
            default:                  item_next.close_kind = nass_pkg::KIND_NONE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (q_wr)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- src/nass_back.sv -----
// Execution stage: track group nesting and element count, build each result word.
`default_nettype none

module nass_back #(
    parameter int unsigned     MAX_NEST     = nass_pkg::NASS_MAX_NEST_DEF,
    parameter longint unsigned MAX_ELEMENTS = nass_pkg::NASS_MAX_ELEMENTS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire nass_pkg::item_t q_data,
    output logic               q_rd,
    input  wire logic          out_full,
    output logic               out_wr,
    output nass_pkg::res_t     out_data,
    output nass_pkg::back_stat_t stat
);

    localparam int unsigned     NEST_W   = $clog2(MAX_NEST + 1);
    localparam longint unsigned CAP_WIDE = (MAX_ELEMENTS - 1 > 65535) ? 65535
                                                                        : MAX_ELEMENTS - 1;
    localparam logic [15:0]     ELEM_CAP = CAP_WIDE[15:0];

    nass_pkg::kind_t  kind_reg;
    nass_pkg::kind_t  kind_next;
    logic [NEST_W-1:0] nest_reg;
    logic [NEST_W-1:0] nest_next;
    logic              bs_reg;
    logic              bs_next;
    logic [15:0]       count_reg;
    logic [15:0]       count_next;
    logic              role;
    logic [1:0]        err;

    assign q_rd   = !q_empty && !out_full;
    assign out_wr = q_rd;

    always_comb
    begin
        kind_next  = kind_reg;
        nest_next  = nest_reg;
        count_next = count_reg;
        role       = nass_pkg::ROLE_CONTENT;
        err        = nass_pkg::ERR_NONE;
        bs_next    = q_data.is_bs;
        unique case (kind_reg)
            nass_pkg::KIND_NONE:
            begin
                if (q_data.open_kind != nass_pkg::KIND_NONE)
                begin
                    kind_next = q_data.open_kind;
                    nest_next = '0;
                end
                else if (q_data.is_sep)
                begin
                    role = nass_pkg::ROLE_SEP;
                    if (count_reg < ELEM_CAP)
                    begin
                        count_next = count_reg + 16'd1;
                    end
                end
            end
            nass_pkg::KIND_QUOTE:
            begin
                if (q_data.open_kind == nass_pkg::KIND_QUOTE && !bs_reg)
                begin
                    kind_next = nass_pkg::KIND_NONE;
                end
            end
            default:
            begin
                if (q_data.close_kind == kind_reg)
                begin
                    if (nest_reg == '0)
                    begin
                        kind_next = nass_pkg::KIND_NONE;
                    end
                    else
                    begin
                        nest_next = nest_reg - NEST_W'(1);
                    end
                end
                else if (q_data.open_kind == kind_reg)
                begin
                    if (nest_reg < NEST_W'(MAX_NEST))
                    begin
                        nest_next = nest_reg + NEST_W'(1);
                    end
                    else
                    begin
                        err = nass_pkg::ERR_OVERFLOW;
                    end
                end
            end
        endcase
        if (q_data.last_char)
        begin
            if (kind_next != nass_pkg::KIND_NONE && kind_next != nass_pkg::KIND_QUOTE)
            begin
                err = nass_pkg::ERR_UNCLOSED;
            end
            kind_next  = nass_pkg::KIND_NONE;
            nest_next  = '0;
            bs_next    = 1'b0;
            count_next = '0;
        end
    end

    always_comb
    begin
        out_data.char_out       = q_data.char_in;
        out_data.role           = role;
        out_data.element_number = count_reg;
        out_data.end_of_text    = q_data.last_char;
        out_data.error_code     = err;
    end

    assign stat.pop   = q_rd;
    assign stat.last  = q_data.last_char;
    assign stat.kind  = kind_reg;
    assign stat.count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= nass_pkg::KIND_NONE;
            nest_reg  <= '0;
            bs_reg    <= 1'b0;
            count_reg <= '0;
        end
        else if (q_rd)
        begin
            kind_reg  <= kind_next;
            nest_reg  <= nest_next;
            bs_reg    <= bs_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- bench/nested_aware_separator_splitter_tb.sv -----
// Self-checking testbench for the bracket-aware separator splitter: directed and random texts.
`default_nettype none

module nested_aware_separator_splitter_tb;

    localparam int unsigned NEST_LIMIT = 255;
    localparam logic [15:0] ELEM_CAP   = 16'd65534;
    localparam logic [7:0]  SPECIALS [8] = '{nass_pkg::CH_SQ_OPEN, nass_pkg::CH_SQ_CLOSE,
        nass_pkg::CH_PAREN_OPEN, nass_pkg::CH_PAREN_CLOSE, nass_pkg::CH_CURLY_OPEN,
        nass_pkg::CH_CURLY_CLOSE, nass_pkg::CH_QUOTE, nass_pkg::CH_BACKSLASH};

    class splitter_scoreboard;
        logic [7:0]      sep = nass_pkg::NASS_SEP_RESET;
        nass_pkg::kind_t kind = nass_pkg::KIND_NONE;
        int unsigned     depth = 0;
        logic            prev_bs = 1'b0;
        logic [15:0]     elem_cnt = '0;
        nass_pkg::res_t  words_due[$];
        int              errors = 0;

        function nass_pkg::kind_t kind_of(logic [7:0] c);
            case (c)
                nass_pkg::CH_SQ_OPEN:    return nass_pkg::KIND_SQUARE;
                nass_pkg::CH_PAREN_OPEN: return nass_pkg::KIND_PAREN;
                nass_pkg::CH_CURLY_OPEN: return nass_pkg::KIND_CURLY;
                nass_pkg::CH_QUOTE:      return nass_pkg::KIND_QUOTE;
                default:                 return nass_pkg::KIND_NONE;
            endcase
        endfunction

        function logic [7:0] open_char(nass_pkg::kind_t k);
            case (k)
                nass_pkg::KIND_SQUARE: return nass_pkg::CH_SQ_OPEN;
                nass_pkg::KIND_PAREN:  return nass_pkg::CH_PAREN_OPEN;
                default:               return nass_pkg::CH_CURLY_OPEN;
            endcase
        endfunction

        function logic [7:0] close_char(nass_pkg::kind_t k);
            case (k)
                nass_pkg::KIND_SQUARE: return nass_pkg::CH_SQ_CLOSE;
                nass_pkg::KIND_PAREN:  return nass_pkg::CH_PAREN_CLOSE;
                default:               return nass_pkg::CH_CURLY_CLOSE;
            endcase
        endfunction

        function int pending();
            return words_due.size();
        endfunction

        function void note_char(logic [7:0] c, logic l);
            nass_pkg::res_t  w;
            nass_pkg::kind_t k;
            w.char_out       = c;
            w.role           = nass_pkg::ROLE_CONTENT;
            w.element_number = elem_cnt;
            w.end_of_text    = l;
            w.error_code     = nass_pkg::ERR_NONE;
            k = kind_of(c);
            if (kind == nass_pkg::KIND_NONE)
            begin
                if (k != nass_pkg::KIND_NONE)
                begin
                    kind  = k;
                    depth = 0;
                end
                else if (c == sep)
                begin
                    w.role = nass_pkg::ROLE_SEP;
                    if (elem_cnt < ELEM_CAP)
                        elem_cnt++;
                end
            end
            else if (kind == nass_pkg::KIND_QUOTE)
            begin
                if (c == nass_pkg::CH_QUOTE && !prev_bs)
                    kind = nass_pkg::KIND_NONE;
            end
            else if (c == close_char(kind))
            begin
                if (depth == 0)
                    kind = nass_pkg::KIND_NONE;
                else
                    depth--;
            end
            else if (c == open_char(kind))
            begin
                if (depth < NEST_LIMIT)
                    depth++;
                else
                    w.error_code = nass_pkg::ERR_OVERFLOW;
            end
            prev_bs = (c == nass_pkg::CH_BACKSLASH);
            if (l)
            begin
                if (kind != nass_pkg::KIND_NONE && kind != nass_pkg::KIND_QUOTE)
                    w.error_code = nass_pkg::ERR_UNCLOSED;
                kind     = nass_pkg::KIND_NONE;
                depth    = 0;
                prev_bs  = 1'b0;
                elem_cnt = '0;
            end
            words_due.insert(words_due.size(), w);
        endfunction

        function void mismatch(string field, logic [15:0] want, logic [15:0] seen);
            $display("%0t: %s expected %h got %h", $time, field, want, seen);
            errors++;
        endfunction

        function void check_word(nass_pkg::res_t seen);
            nass_pkg::res_t w;
            if (words_due.size() == 0)
            begin
                $display("%0t: result word %h expected none got one", $time, seen);
                errors++;
                return;
            end
            w = words_due.pop_front();
            if (seen.char_out !== w.char_out)
                mismatch("char_out", w.char_out, seen.char_out);
            if (seen.role !== w.role)
                mismatch("role", w.role, seen.role);
            if (seen.element_number !== w.element_number)
                mismatch("element_number", w.element_number, seen.element_number);
            if (seen.end_of_text !== w.end_of_text)
                mismatch("end_of_text", w.end_of_text, seen.end_of_text);
            if (seen.error_code !== w.error_code)
                mismatch("error_code", w.error_code, seen.error_code);
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           push;
    logic           full;
    logic [7:0]     char_in;
    logic           last_char;
    logic           empty;
    logic           pop;
    logic [7:0]     char_out;
    logic           role;
    logic [15:0]    element_number;
    logic           end_of_text;
    logic [1:0]     error_code;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [7:0]     separator_char;
    nass_pkg::res_t seen_word;

    splitter_scoreboard sb = new;
    logic [7:0]  text_q[$];
    bit          calm = 1'b0;
    int unsigned hold_req = 0;

    nested_aware_separator_splitter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .char_in        (char_in),
        .last_char      (last_char),
        .empty          (empty),
        .pop            (pop),
        .char_out       (char_out),
        .role           (role),
        .element_number (element_number),
        .end_of_text    (end_of_text),
        .error_code     (error_code),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .separator_char (separator_char)
    );

    assign seen_word = {char_out, role, element_number, end_of_text, error_code};

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        if (rst_n && pop && !empty)
            sb.check_word(seen_word);

    function automatic void add_char(logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 8);
    endfunction

    function automatic logic [7:0] letter();
        return 8'h61 + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] any_char();
        int unsigned r = $urandom_range(99);
        if (r < 10)
            return sb.sep;
        if (r < 45)
            return SPECIALS[3'($urandom_range(7))];
        if (r < 50)
            return 8'h00;
        if (r < 55)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic void build_well_formed();
        int unsigned     n_elems = $urandom_range(1, 6);
        int unsigned     lvl;
        int unsigned     r;
        nass_pkg::kind_t k;
        logic [7:0]      c;
        text_q.delete();
        for (int e = 0; e < n_elems; e++)
        begin
            if (e != 0)
                add_char(sb.sep);
            case ($urandom_range(3))
                0: repeat ($urandom_range(0, 4)) add_char(letter());
                1:
                begin
                    add_char(nass_pkg::CH_QUOTE);
                    repeat ($urandom_range(0, 5))
                    begin
                        if ($urandom_range(4) == 0)
                        begin
                            add_char(nass_pkg::CH_BACKSLASH);
                            add_char(nass_pkg::CH_QUOTE);
                        end
                        else
                        begin
                            c = any_char();
                            if (c == nass_pkg::CH_QUOTE || c == nass_pkg::CH_BACKSLASH)
                                c = letter();
                            add_char(c);
                        end
                    end
                    add_char(nass_pkg::CH_QUOTE);
                end
                default:
                begin
                    k = nass_pkg::kind_t'($urandom_range(1, 3));
                    add_char(sb.open_char(k));
                    lvl = 0;
                    repeat ($urandom_range(0, 8))
                    begin
                        r = $urandom_range(99);
                        if (r < 20)
                        begin
                            add_char(sb.open_char(k));
                            lvl++;
                        end
                        else if (r < 40 && lvl != 0)
                        begin
                            add_char(sb.close_char(k));
                            lvl--;
                        end
                        else
                        begin
                            c = any_char();
                            if (c == sb.open_char(k) || c == sb.close_char(k))
                                c = letter();
                            add_char(c);
                        end
                    end
                    repeat (lvl + 1) add_char(sb.close_char(k));
                end
            endcase
        end
        if (text_q.size() == 0)
            add_char(letter());
    endfunction

    task automatic send_char(logic [7:0] c, logic l);
        @(negedge clk);
        while (take_break())
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        char_in   <= c;
        last_char <= l;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_char(c, l);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_text(int pause_at = -1);
        foreach (text_q[i])
        begin
            if (i == pause_at)
                wait_drained();
            send_char(text_q[i], i == text_q.size() - 1);
        end
    endtask

    task automatic send_string(string s);
        text_q.delete();
        foreach (s[i]) add_char(s[i]);
        send_text();
    endtask

    task automatic write_sep(logic [7:0] v);
        wait_drained();
        @(negedge clk);
        cfg_valid      <= 1'b1;
        separator_char <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.sep = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_texts(int unsigned n_items);
        int unsigned sent = 0;
        int unsigned r;
        int          pause_at;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (r < 88)
            begin
                build_well_formed();
                if (r >= 75)
                    while (text_q.size() > 1 && $urandom_range(3) != 0)
                        void'(text_q.pop_back());
            end
            else
            begin
                text_q.delete();
                repeat ($urandom_range(1, 20)) add_char(any_char());
            end
            sent += text_q.size();
            pause_at = -1;
            if ($urandom_range(9) == 0)
                pause_at = $urandom_range(text_q.size() - 1);
            send_text(pause_at);
        end
    endtask

    initial
    begin
        int unsigned seen_req;
        int unsigned hold_left;
        seen_req  = 0;
        hold_left = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req != seen_req)
            begin
                seen_req  = hold_req;
                hold_left = 120;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= !take_break();
        end
    end

    initial
    begin
        push           = 1'b0;
        char_in        = '0;
        last_char      = 1'b0;
        cfg_valid      = 1'b0;
        separator_char = nass_pkg::NASS_SEP_RESET;
        rst_n          = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        text_q = '{8'h00, nass_pkg::NASS_SEP_RESET, 8'hFF};
        send_text();
        send_string("[,],");
        send_string("(x");
        send_string("\"a\\\",\",");
        send_string("{{}");
        send_string("\"x");
        send_string(",");

        text_q.delete();
        repeat (257) add_char(nass_pkg::CH_PAREN_OPEN);
        send_text();

        random_texts(25);
        write_sep(8'h00);
        random_texts(20);
        write_sep(8'hFF);
        random_texts(20);
        write_sep(nass_pkg::CH_SQ_OPEN);
        random_texts(20);
        write_sep(nass_pkg::CH_SQ_CLOSE);
        random_texts(20);
        write_sep(nass_pkg::CH_QUOTE);
        random_texts(20);
        write_sep(nass_pkg::CH_BACKSLASH);
        random_texts(20);

        write_sep(8'($urandom));
        calm = 1'b1;
        hold_req++;
        random_texts(30);
        calm = 1'b0;

        write_sep(nass_pkg::NASS_SEP_RESET);
        random_texts(25);

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
